>>> rtl/bpqt_pkg.sv
// ----------------------------------------------------------------------------
// bpqt_pkg
// Shared widths, constants and types of the batch perceptron trainer.
// ----------------------------------------------------------------------------
package bpqt_pkg;

  localparam int FEATURE_COUNT = 6;
  localparam int IDX_W         = 3;
  localparam int X_W           = 16;
  localparam int FEAT_W        = 32;
  localparam int W_W           = 48;
  localparam int ACC_W         = 64;
  localparam int ALPHA_W       = 16;
  localparam int Q_SHIFT       = 16;
  localparam int LIN_SHIFT     = 8;
  localparam int ALPHA_SHIFT   = 8;

  // feature order
  localparam int F_SQ_FIRST   = 0;
  localparam int F_SQ_SECOND  = 1;
  localparam int F_CROSS      = 2;
  localparam int F_LIN_FIRST  = 3;
  localparam int F_LIN_SECOND = 4;
  localparam int F_BIAS       = 5;

  typedef logic signed [W_W-1:0]    weight_t;
  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd256;
  localparam weight_t WEIGHT_ONE = 48'sd65536;
  localparam feat_t   FEAT_ONE   = 32'sd65536;
  localparam weight_t W_MAX      = {1'b0, {(W_W-1){1'b1}}};
  localparam weight_t W_MIN      = {1'b1, {(W_W-1){1'b0}}};
  localparam acc_t    ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t    ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

  // one classified sample, features already negated for the second class
  typedef struct packed {
    feat_t [FEATURE_COUNT-1:0] feat;
    logic                      last;
  } job_t;

  typedef weight_t [FEATURE_COUNT-1:0] weight_vec_t;

endpackage

>>> rtl/batch_perceptron_quadratic_trainer.sv
// ----------------------------------------------------------------------------
// batch_perceptron_quadratic_trainer
// Two-class batch perceptron trainer over quadratic features, fixed point.
// ----------------------------------------------------------------------------
// Each sample beat (x1, x2 in signed Q8.8, class, epoch-last flag) is turned
// into the feature vector [x1^2, x2^2, x1*x2, x1, x2, 1] in Q.16, negated for
// the second class, and dotted with six Q32.16 weights; a strictly negative
// sum marks the sample misclassified and adds its vector to the error sums.
// After an epoch-last sample the weights step by learning_rate (Q8.8) times
// the error sums, which are then cleared. One result beat per sample carries
// the saturated Q48.16 sum and the weights after the step. A front end
// builds the features on a 16x16 multiplier and feeds a short job queue;
// the back end does every weight and update product on one shared 48x16
// multiplier (two passes per feature for weights, one for updates); per
// sample it runs the dot product, a drain and the error-sum step, plus six
// update products and a drain to close an epoch, and it sets the sustained
// rate. The result register lets the next sample start while a result beat
// waits. learning_rate resets to 1.0 and may be written only while idle.
// ----------------------------------------------------------------------------
module batch_perceptron_quadratic_trainer
  import bpqt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample side
  input  logic                  push,
  output logic                  full,
  input  logic signed [X_W-1:0] first_coord,
  input  logic signed [X_W-1:0] second_coord,
  input  logic                  second_class,
  input  logic                  epoch_last,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output logic signed [ACC_W-1:0] weighted_sum,
  output logic                  misclassified,
  output logic                  weights_updated,
  output logic signed [W_W-1:0] weight_sq_first,
  output logic signed [W_W-1:0] weight_sq_second,
  output logic signed [W_W-1:0] weight_cross,
  output logic signed [W_W-1:0] weight_lin_first,
  output logic signed [W_W-1:0] weight_lin_second,
  output logic signed [W_W-1:0] weight_bias,
  // learning rate register
  input  logic                  cfg_we,
  input  logic [ALPHA_W-1:0]    cfg_wdata
);

  logic [ALPHA_W-1:0] learning_rate;

  // front to queue
  logic        fq_push, fq_full;
  job_t        fq_job;
  // queue to back
  logic        qb_empty, qb_pop;
  job_t        qb_job;
  weight_vec_t weights;

  // alpha register, unsigned q8.8
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= ALPHA_RESET;
    end else if (cfg_we) begin
      learning_rate <= cfg_wdata;
    end
  end

  // feature builder
  bpqt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .first_coord  (first_coord),
    .second_coord (second_coord),
    .second_class (second_class),
    .epoch_last   (epoch_last),
    .job_push     (fq_push),
    .job_full     (fq_full),
    .job          (fq_job)
  );

  // decouples the two halves
  bpqt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (fq_push),
    .full   (fq_full),
    .wr_job (fq_job),
    .pop    (qb_pop),
    .empty  (qb_empty),
    .rd_job (qb_job)
  );

  // dot product, error sums, epoch update, result register
  bpqt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (!qb_empty),
    .job             (qb_job),
    .job_pop         (qb_pop),
    .alpha           (learning_rate),
    .empty           (empty),
    .pop             (pop),
    .weighted_sum    (weighted_sum),
    .misclassified   (misclassified),
    .weights_updated (weights_updated),
    .weights         (weights)
  );

  // weights after this beat's step
  assign weight_sq_first   = weights[F_SQ_FIRST];
  assign weight_sq_second  = weights[F_SQ_SECOND];
  assign weight_cross      = weights[F_CROSS];
  assign weight_lin_first  = weights[F_LIN_FIRST];
  assign weight_lin_second = weights[F_LIN_SECOND];
  assign weight_bias       = weights[F_BIAS];

endmodule

>>> rtl/bpqt_front.sv
// ----------------------------------------------------------------------------
// bpqt_front
// Takes a sample and builds its quadratic feature vector with one 16x16
// multiplier that forms x1^2, x2^2 and x1*x2 in turn, then queues it as a job.
// ----------------------------------------------------------------------------
module bpqt_front
  import bpqt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [X_W-1:0] first_coord,
  input  logic signed [X_W-1:0] second_coord,
  input  logic                  second_class,
  input  logic                  epoch_last,
  output logic                  job_push,
  input  logic                  job_full,
  output job_t                  job
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SQ_FIRST  = 3'd1;
  localparam logic [2:0] ST_SQ_SECOND = 3'd2;
  localparam logic [2:0] ST_CROSS     = 3'd3;
  localparam logic [2:0] ST_PUSH      = 3'd4;

  logic [2:0]            state, state_next;
  logic signed [X_W-1:0] x1, x2;
  logic                  neg, last;
  feat_t                 sq_first, sq_second, cross_term;
  logic signed [X_W-1:0] mul_a, mul_b;
  feat_t                 mul_p;
  logic                  accept;
  feat_t                 base [FEATURE_COUNT];

  assign full     = (state != ST_IDLE) && !((state == ST_PUSH) && !job_full);
  assign accept   = push && !full;
  assign job_push = (state == ST_PUSH);

  // operand select: x1*x1, x2*x2, x1*x2
  assign mul_a = (state == ST_SQ_SECOND) ? x2 : x1;
  assign mul_b = (state == ST_SQ_FIRST) ? x1 : x2;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_SQ_FIRST;
      ST_SQ_FIRST:  state_next = ST_SQ_SECOND;
      ST_SQ_SECOND: state_next = ST_CROSS;
      ST_CROSS:     state_next = ST_PUSH;
      ST_PUSH: begin
        if (!job_full) state_next = accept ? ST_SQ_FIRST : ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1   <= first_coord;
      x2   <= second_coord;
      neg  <= second_class;
      last <= epoch_last;
    end
    if (state == ST_SQ_FIRST)  sq_first   <= mul_p;
    if (state == ST_SQ_SECOND) sq_second  <= mul_p;
    if (state == ST_CROSS)     cross_term <= mul_p;
  end

  always_comb begin
    base[F_SQ_FIRST]   = sq_first;
    base[F_SQ_SECOND]  = sq_second;
    base[F_CROSS]      = cross_term;
    base[F_LIN_FIRST]  = feat_t'(x1) <<< LIN_SHIFT;
    base[F_LIN_SECOND] = feat_t'(x2) <<< LIN_SHIFT;
    base[F_BIAS]       = FEAT_ONE;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      job.feat[j] = neg ? -base[j] : base[j];
    end
    job.last = last;
  end

endmodule

>>> rtl/bpqt_queue.sv
// ----------------------------------------------------------------------------
// bpqt_queue
// Short job queue between the feature front end and the training back end.
// ----------------------------------------------------------------------------
module bpqt_queue
  import bpqt_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  job_t wr_job,
  input  logic pop,
  output logic empty,
  output job_t rd_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en, rd_en;

  assign full   = (count == CNT_FULL);
  assign empty  = (count == '0);
  assign wr_en  = push && !full;
  assign rd_en  = pop && !empty;
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entries[wr_ptr] <= wr_job;
  end

endmodule

>>> rtl/bpqt_back.sv
// ----------------------------------------------------------------------------
// bpqt_back
// Weight and error-sum storage, dot product and epoch update through one
// shared 48x16 multiplier, and the result register.
// ----------------------------------------------------------------------------
module bpqt_back
  import bpqt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  job_t               job,
  output logic               job_pop,
  input  logic [ALPHA_W-1:0] alpha,
  output logic               empty,
  input  logic               pop,
  output acc_t               weighted_sum,
  output logic               misclassified,
  output logic               weights_updated,
  output weight_vec_t        weights
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DOT       = 3'd1;
  localparam logic [2:0] ST_DOT_DRAIN = 3'd2;
  localparam logic [2:0] ST_ERR       = 3'd3;
  localparam logic [2:0] ST_UPD       = 3'd4;
  localparam logic [2:0] ST_UPD_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  localparam int STEP_W  = $clog2(2 * FEATURE_COUNT);
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = W_W + MUL_B_W;
  localparam int PART_W  = PROD_W - Q_SHIFT;
  localparam int UPD_W   = W_W + 10;
  localparam logic [STEP_W-1:0] DOT_LAST = STEP_W'(2 * FEATURE_COUNT - 1);
  localparam logic [STEP_W-1:0] UPD_LAST = STEP_W'(FEATURE_COUNT - 1);

  typedef struct packed {
    logic             valid;
    logic             upd;
    logic             half;
    logic             neg;
    logic [IDX_W-1:0] idx;
  } tag_t;

  function automatic weight_t clamp_w(input logic signed [UPD_W-1:0] v);
    logic fits;
    fits = (v[UPD_W-1:W_W-1] == '0) || (v[UPD_W-1:W_W-1] == '1);
    if (fits) return v[W_W-1:0];
    return v[UPD_W-1] ? W_MIN : W_MAX;
  endfunction

  function automatic acc_t add_sat(input acc_t a, input acc_t b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  logic [2:0]          state, state_next;
  logic [STEP_W-1:0]   step;
  job_t                job_reg;
  acc_t                acc;
  weight_t             w  [FEATURE_COUNT];
  weight_t             es [FEATURE_COUNT];
  logic                out_valid;
  logic                load_out;

  // issue stage
  logic                issue_valid;
  logic [IDX_W-1:0]    idx_issue;
  logic [IDX_W-1:0]    w_idx;
  weight_t             w_sel;
  feat_t               f_sel;
  weight_t             es_sel;
  logic [FEAT_W-1:0]   mag_f;
  logic [W_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                neg_issue;
  logic [PROD_W-1:0]   mul_p;

  // combine and accumulate stages
  tag_t                m_tag, t_tag;
  logic [PROD_W-1:0]   mul_reg;
  logic [PART_W-1:0]   part_reg;
  logic [PROD_W-1:0]   c_mag;
  acc_t                term_reg;
  logic signed [UPD_W-1:0] w_sum;
  logic                es_zero;

  assign issue_valid = (state == ST_DOT) || (state == ST_UPD);
  assign idx_issue   = (state == ST_DOT) ? step[STEP_W-1:1] : step[IDX_W-1:0];
  // weight read port: dot issue, otherwise the update write-back
  assign w_idx       = (state == ST_DOT) ? idx_issue : t_tag.idx;
  assign w_sel       = w[w_idx];
  assign es_sel      = es[idx_issue];
  assign f_sel       = $signed(job_reg.feat[idx_issue]);
  assign mag_f       = f_sel[FEAT_W-1] ? (~f_sel + 1'b1) : f_sel;

  always_comb begin
    if (state == ST_UPD) begin
      mul_a     = es_sel[W_W-1] ? (~es_sel + 1'b1) : es_sel;
      mul_b     = alpha;
      neg_issue = es_sel[W_W-1];
    end else begin
      mul_a     = w_sel[W_W-1] ? (~w_sel + 1'b1) : w_sel;
      mul_b     = step[0] ? mag_f[FEAT_W-1:Q_SHIFT] : mag_f[Q_SHIFT-1:0];
      neg_issue = w_sel[W_W-1] ^ f_sel[FEAT_W-1];
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // product magnitude: high half plus truncated low half, or alpha scaling
  assign c_mag = m_tag.upd ? (mul_reg >> ALPHA_SHIFT) : (mul_reg + PROD_W'(part_reg));
  assign w_sum = UPD_W'(w_sel) + $signed(term_reg[UPD_W-1:0]);

  assign job_pop  = (state == ST_IDLE) && job_valid;
  assign load_out = (state == ST_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (job_valid) state_next = ST_DOT;
      ST_DOT:       if (step == DOT_LAST) state_next = ST_DOT_DRAIN;
      ST_DOT_DRAIN: if (!m_tag.valid && !t_tag.valid) state_next = ST_ERR;
      ST_ERR:       state_next = job_reg.last ? ST_UPD : ST_DONE;
      ST_UPD:       if (step == UPD_LAST) state_next = ST_UPD_DRAIN;
      ST_UPD_DRAIN: if (!m_tag.valid && !t_tag.valid) state_next = ST_DONE;
      ST_DONE:      if (load_out) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      m_tag     <= '0;
      t_tag     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (issue_valid && (state_next == state)) step <= step + 1'b1;
      else                                      step <= '0;
      m_tag <= '{valid: issue_valid, upd: (state == ST_UPD), half: step[0],
                 neg: neg_issue, idx: idx_issue};
      // low halves only feed part_reg, so they never reach the accumulator
      t_tag <= '{valid: m_tag.valid && (m_tag.upd || m_tag.half), upd: m_tag.upd,
                 half: m_tag.half, neg: m_tag.neg, idx: m_tag.idx};
      if (load_out)                out_valid <= 1'b1;
      else if (pop && out_valid)   out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (job_pop) job_reg <= job;
    mul_reg <= mul_p;
    if (m_tag.valid && !m_tag.upd && !m_tag.half) part_reg <= mul_reg[PROD_W-1:Q_SHIFT];
    term_reg <= m_tag.neg ? (~c_mag + 1'b1) : c_mag;
    if (job_pop) begin
      acc <= '0;
    end else if (t_tag.valid && !t_tag.upd) begin
      acc <= add_sat(acc, term_reg);
    end
  end

  // weight and error-sum storage
  always_ff @(posedge clk) begin
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      if (rst) begin
        w[j]  <= WEIGHT_ONE;
        es[j] <= '0;
      end else begin
        if (t_tag.valid && t_tag.upd && (t_tag.idx == IDX_W'(j))) begin
          w[j]  <= clamp_w(w_sum);
          es[j] <= '0;
        end else if ((state == ST_ERR) && acc[ACC_W-1]) begin
          es[j] <= clamp_w(UPD_W'(es[j]) + UPD_W'($signed(job_reg.feat[j])));
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      weighted_sum    <= acc;
      misclassified   <= acc[ACC_W-1];
      weights_updated <= job_reg.last;
      for (int j = 0; j < FEATURE_COUNT; j++) begin
        weights[j] <= w[j];
      end
    end
  end

  always_comb begin
    es_zero = 1'b1;
    for (int j = 0; j < FEATURE_COUNT; j++) begin
      if (es[j] != '0) es_zero = 1'b0;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!m_tag.valid && !t_tag.valid))
    else $error("multiplier pipeline busy while idle");

  a_epoch_clears_sum: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && job_reg.last) |-> es_zero)
    else $error("error sum not cleared at epoch end");

  a_result_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (misclassified == weighted_sum[ACC_W-1]))
    else $error("misclassified flag disagrees with sum sign");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside done state");

endmodule
